/* hdl/column_mean_projection_unit_defines.svh */
// Assertion macros for the checker file of the column mean projection unit.
// No dependencies; included by bare file name.
`ifndef COLUMN_MEAN_PROJECTION_UNIT_DEFINES_SVH
`define COLUMN_MEAN_PROJECTION_UNIT_DEFINES_SVH

// Next-cycle implication, checked outside reset
`define CMP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, checked during reset too
`define CMP_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/cmp_pkg.sv */
// Package for the column mean projection unit: sizes, command codes, divider status type.
// No dependencies; imported by cmp_div, the top level, the checker and the testbench.
`timescale 1ns / 1ps

package cmp_pkg;

   localparam int MAX_COLS  = 2048;
   localparam int CHANNELS  = 3;

   localparam int COL_BITS  = 11;
   localparam int CHAN_BITS = 8;
   localparam int ROWS_BITS = 11;
   localparam int MEAN_BITS = 8;
   localparam int SUM_BITS  = 20;

   localparam int ADDR_BITS = $clog2(MAX_COLS);
   localparam int DIV_BITS  = ROWS_BITS + $clog2(CHANNELS + 1);
   localparam int PIX_BITS  = CHAN_BITS + 2;

   localparam int REQ_DATA_BITS = 40;
   localparam int RSP_DATA_BITS = 24;

   localparam logic [ROWS_BITS-1:0] ROWS_RESET = 11'd720;

   typedef enum logic [1:0] {
      CMD_ACCUM = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2
   } command_type;

   // divider status seen by the sequencer
   typedef struct packed {
      logic                 busy;
      logic [MEAN_BITS-1:0] quotient;
   } div_status_type;

endpackage

/* hdl/cmp_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the column sum store.
`timescale 1ns / 1ps

module cmp_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/cmp_div.sv */
// Iterative compare-subtract divider: sum / divisor, quotient clamped to 8 bits.
// Depends on cmp_pkg.
`timescale 1ns / 1ps

module cmp_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [cmp_pkg::SUM_BITS-1:0]   dividend,
   input  logic [cmp_pkg::DIV_BITS-1:0]   divisor,
   output cmp_pkg::div_status_type        status
);

   import cmp_pkg::*;

   localparam int SH_BITS   = DIV_BITS + MEAN_BITS;
   localparam int CMP_BITS  = (SUM_BITS > SH_BITS) ? SUM_BITS : SH_BITS;
   localparam int STEP_BITS = $clog2(MEAN_BITS + 1);

   logic                 busy_ff, busy_in;
   logic [STEP_BITS-1:0] step_ff, step_in;
   logic [SUM_BITS-1:0]  rem_ff, rem_in;
   logic [SH_BITS-1:0]   sh_ff, sh_in;
   logic [MEAN_BITS-1:0] quo_ff, quo_in;
   logic                 fits;

   // one shared compare against the shifted divisor
   assign fits = CMP_BITS'(rem_ff) >= CMP_BITS'(sh_ff);

   // first step tests for an overflowing quotient (also catches a zero divisor),
   // the rest are restoring steps, one quotient bit each
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_BITS'(MEAN_BITS);
         rem_in  = dividend;
         sh_in   = {divisor, MEAN_BITS'(0)};
         quo_in  = '0;
      end else if (busy_ff) begin
         sh_in   = sh_ff >> 1;
         step_in = step_ff - STEP_BITS'(1);
         if (step_ff == STEP_BITS'(MEAN_BITS)) begin
            if (fits) begin
               quo_in  = '1;
               busy_in = 1'b0;
            end
         end else begin
            if (fits) begin
               rem_in = rem_ff - SUM_BITS'(sh_ff);
               quo_in = quo_ff | (MEAN_BITS'(1) << step_ff);
            end
            if (step_ff == '0) begin
               busy_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      sh_ff   <= sh_in;
      quo_ff  <= quo_in;
   end

   assign status.busy     = busy_ff;
   assign status.quotient = quo_ff;

endmodule

/* hdl/column_mean_projection_unit.sv */
// Column mean projection unit: per-column pixel sums and mean readout.
// Depends on cmp_pkg, cmp_ram and cmp_div.
`timescale 1ns / 1ps

// Usage:
//  req_* carries command words: accumulate a pixel into its column sum,
//  read a column mean, or clear a column sum. Only a read returns a word
//  on rsp_*, holding the column and the mean min(255, sum / (rows * 3)).
//  csr_wr_en / csr_wr_data set the rows per frame (720 after reset); write
//  it only while the block is idle.
// Steps, per accepted word:
//  clear: one RAM write; accumulate: one read-modify-write of the sum RAM;
//  read: accept with RAM fetch, divider start, 9 steps of the shared
//  compare-subtract divider, then the load of the output register. A mean that
//  clamps (zero rows included) ends after the first step.
// Reset:
//  a clearing pass writes zero to all 2048 column sums, one per cycle, and
//  req_tready stays low until the pass ends; csr writes are taken as usual.
// Stall:
//  a read result waits in the output register until rsp_tready; the next word
//  is still accepted, and a following read waits at its end for the slot.
module column_mean_projection_unit (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: column[10:0], chan_a[18:11], chan_b[26:19], chan_c[34:27], zero pad
   input  logic [cmp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   // req_tuser: command[1:0]
   input  logic [1:0]                          req_tuser,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // rsp_tdata: out_column[10:0], mean[18:11], zero pad
   output logic [cmp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_wr_en,
   input  logic [cmp_pkg::ROWS_BITS-1:0]       csr_wr_data
);

   import cmp_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DIV
   } state_type;

   state_type            state_ff, state_in;
   logic [ADDR_BITS-1:0] clr_ff, clr_in;
   logic [ROWS_BITS-1:0] rows_ff, rows_in;
   command_type          cmd_ff, cmd_in;
   logic [COL_BITS-1:0]  col_ff, col_in;
   logic                 ok_ff, ok_in;
   logic [PIX_BITS-1:0]  pix_ff, pix_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [COL_BITS-1:0]  rsp_col_ff, rsp_col_in;
   logic [MEAN_BITS-1:0] rsp_mean_ff, rsp_mean_in;

   command_type          req_cmd;
   logic [COL_BITS-1:0]  req_col;
   logic [CHAN_BITS-1:0] req_a, req_b, req_c;
   logic                 req_ok;

   logic                 ram_wr_en, ram_rd_en;
   logic [ADDR_BITS-1:0] ram_wr_addr, ram_rd_addr;
   logic [SUM_BITS-1:0]  ram_wr_data, ram_rd_data;
   logic [SUM_BITS:0]    sum_wide;
   logic [SUM_BITS-1:0]  sum_sat;

   logic                 div_start;
   logic [DIV_BITS-1:0]  divisor;
   div_status_type       div_status;

   // input word unpacking
   assign req_cmd = command_type'(req_tuser);
   assign req_col = req_tdata[COL_BITS-1:0];
   assign req_a   = req_tdata[COL_BITS +: CHAN_BITS];
   assign req_b   = req_tdata[COL_BITS + CHAN_BITS +: CHAN_BITS];
   assign req_c   = req_tdata[COL_BITS + 2*CHAN_BITS +: CHAN_BITS];
   assign req_ok  = int'(req_col) < MAX_COLS;

   // saturating add of the pixel total to the fetched sum
   assign sum_wide = {1'b0, ram_rd_data} + (SUM_BITS+1)'(pix_ff);
   assign sum_sat  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

   assign divisor  = DIV_BITS'(rows_ff * CHANNELS);

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      rows_in      = csr_wr_en ? csr_wr_data : rows_ff;
      cmd_in       = cmd_ff;
      col_in       = col_ff;
      ok_in        = ok_ff;
      pix_in       = pix_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_col_in   = rsp_col_ff;
      rsp_mean_in  = rsp_mean_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = ADDR_BITS'(col_ff);
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ADDR_BITS'(req_col);
      div_start    = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_ff;
            clr_in      = clr_ff + ADDR_BITS'(1);
            if (clr_ff == ADDR_BITS'(MAX_COLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd_in = req_cmd;
               col_in = req_col;
               ok_in  = req_ok;
               pix_in = PIX_BITS'(req_a) + PIX_BITS'(req_b) + PIX_BITS'(req_c);
               unique case (req_cmd)
                  CMD_ACCUM, CMD_READ: begin
                     ram_rd_en = 1'b1;
                     state_in  = ST_FETCH;
                  end
                  CMD_CLEAR: begin
                     ram_wr_en   = req_ok;
                     ram_wr_addr = ADDR_BITS'(req_col);
                  end
                  default: ;
               endcase
            end
         end
         ST_FETCH: begin
            if (cmd_ff == CMD_READ) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               ram_wr_en   = ok_ff;
               ram_wr_data = sum_sat;
               state_in    = ST_IDLE;
            end
         end
         ST_DIV: begin
            // hand the quotient to the output register once the divider is done and the register is free
            if (!div_status.busy && (!rsp_valid_ff || rsp_tready)) begin
               rsp_valid_in = 1'b1;
               rsp_col_in   = col_ff;
               rsp_mean_in  = ok_ff ? div_status.quotient : '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rows_ff      <= ROWS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rows_ff      <= rows_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff      <= cmd_in;
      col_ff      <= col_in;
      ok_ff       <= ok_in;
      pix_ff      <= pix_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_mean_ff <= rsp_mean_in;
   end

   // column sum store
   cmp_ram #(
      .WIDTH (SUM_BITS),
      .DEPTH (MAX_COLS)
   ) u_sum_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // shared divider
   cmp_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (ram_rd_data),
      .divisor  (divisor),
      .status   (div_status)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - COL_BITS - MEAN_BITS)'(0), rsp_mean_ff, rsp_col_ff};

endmodule

/* hdl/cmp_checker.sv */
// Port-level checker for the column mean projection unit, bound to the top level.
// Depends on cmp_pkg and column_mean_projection_unit_defines.svh.
`timescale 1ns / 1ps
`include "column_mean_projection_unit_defines.svh"

module cmp_checker (
   input logic                                clock,
   input logic                                reset,
   input logic [cmp_pkg::REQ_DATA_BITS-1:0]   req_tdata,
   input logic [1:0]                          req_tuser,
   input logic                                req_tvalid,
   input logic                                req_tready,
   input logic [cmp_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic                                csr_wr_en,
   input logic [cmp_pkg::ROWS_BITS-1:0]       csr_wr_data
);

   import cmp_pkg::*;

   logic rmw_word;
   logic rsp_stall;

   // words that go through the RAM, and a result held off by the receiver
   assign rmw_word  = req_tvalid && req_tready
                      && (req_tuser == CMD_ACCUM || req_tuser == CMD_READ);
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   // reset starts the clearing pass, so no word is taken right after it
   `CMP_ASSERT_NEXT_ALWAYS(a_reset_blocks, reset, !req_tready, "ready right after reset")

   // accumulate and read words go through the RAM, so ready drops
   `CMP_ASSERT_NEXT(a_busy_after_rmw, rmw_word, !req_tready, "ready held during fetch")

   // a stalled result word holds
   `CMP_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_tvalid && $stable(rsp_tdata), "result word changed")

endmodule

bind column_mean_projection_unit cmp_checker u_cmp_checker (.*);

/* tb/column_mean_projection_unit_tb.sv */
// Testbench for the column mean projection unit: directed table, overflow burst, random phases.
// Depends on cmp_pkg and the RTL of column_mean_projection_unit; self-checking against an
// internal model of the column sums.
`timescale 1ns / 1ps

module column_mean_projection_unit_tb;

   import cmp_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 12;
   localparam int SETTLE_CYCLES   = 20;      // longest word in flight is a read
   localparam int STALL_LIMIT     = 6000;    // covers the clearing pass after reset
   localparam int LONG_HOLD       = 400;
   localparam int MAX_GAP         = 16;
   localparam int SATURATE_WORDS  = 1400;    // 1400 * 765 passes the 20-bit sum limit
   localparam int NUM_PHASES      = 8;
   localparam int PHASE_WORDS     = 25;
   localparam int HOT_COLS        = 6;
   localparam int NUM_DIRECTED    = 24;

   localparam logic [1:0]          CMD_UNUSED = 2'd3;
   localparam logic [SUM_BITS-1:0] SUM_LIMIT  = {SUM_BITS{1'b1}};
   localparam int                  MEAN_LIMIT = 255;

   // one row of the directed table: either a command word or a rows write
   typedef struct packed {
      logic                 is_csr;
      logic [1:0]           cmd;
      logic [COL_BITS-1:0]  col;
      logic [CHAN_BITS-1:0] chan_a;
      logic [CHAN_BITS-1:0] chan_b;
      logic [CHAN_BITS-1:0] chan_c;
      logic [ROWS_BITS-1:0] rows;
      logic                 typed;
      logic [MEAN_BITS-1:0] mean;
   } stim_row_type;

   typedef struct {
      logic [COL_BITS-1:0]  column;
      logic [MEAN_BITS-1:0] mean;
   } mean_word_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic [1:0]               req_tuser   = '0;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic                     csr_wr_en   = 1'b0;
   logic [ROWS_BITS-1:0]     csr_wr_data = '0;

   // model state
   logic [SUM_BITS-1:0]  sum_store [MAX_COLS];
   logic [ROWS_BITS-1:0] rows_setting = ROWS_RESET;
   mean_word_type        pending_means [$];

   int errors        = 0;
   int hold_requests = 0;
   int holds_done    = 0;
   bit idle_off      = 1'b0;
   int quiet_cycles  = 0;

   column_mean_projection_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   // Column sum model: applies one accepted word, returns 1 when a read produces a mean
   function automatic bit update_profile(input logic [1:0] cmd,
                                         input logic [COL_BITS-1:0] col,
                                         input logic [CHAN_BITS-1:0] a, b, c,
                                         output logic [MEAN_BITS-1:0] mean);
      int unsigned total;
      int unsigned divisor;
      int unsigned quot;
      bit          produced;
      mean = '0;
      produced = 1'b0;
      case (cmd)
         CMD_ACCUM: begin
            total = sum_store[col] + a + b + c;
            sum_store[col] = (total > SUM_LIMIT) ? SUM_LIMIT : total[SUM_BITS-1:0];
         end
         CMD_READ: begin
            divisor = rows_setting * CHANNELS;
            // zero rows behaves as a saturating divide
            if (divisor == 0) quot = MEAN_LIMIT;
            else quot = sum_store[col] / divisor;
            mean = (quot > MEAN_LIMIT) ? MEAN_LIMIT[MEAN_BITS-1:0] : quot[MEAN_BITS-1:0];
            produced = 1'b1;
         end
         CMD_CLEAR: sum_store[col] = '0;
         default: ;  // unused command: nothing happens
      endcase
      return produced;
   endfunction

   function automatic int draw_gap();
      return idle_off ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   // mostly uniform, with the extremes showing up often
   function automatic logic [CHAN_BITS-1:0] draw_channel();
      int r;
      r = $urandom_range(0, 99);
      if (r < 10) return '1;
      if (r < 15) return '0;
      return CHAN_BITS'($urandom_range(0, 255));
   endfunction

   function automatic stim_row_type cmd_row(input logic [1:0] cmd,
                                            input logic [COL_BITS-1:0] col,
                                            input logic [CHAN_BITS-1:0] a, b, c);
      return '{1'b0, cmd, col, a, b, c, '0, 1'b0, '0};
   endfunction

   function automatic stim_row_type read_row(input logic [COL_BITS-1:0] col,
                                             input logic [MEAN_BITS-1:0] mean);
      return '{1'b0, CMD_READ, col, '0, '0, '0, '0, 1'b1, mean};
   endfunction

   function automatic stim_row_type cfg_row(input logic [ROWS_BITS-1:0] rows);
      return '{1'b1, CMD_ACCUM, '0, '0, '0, '0, rows, 1'b0, '0};
   endfunction

   // Offer one command word, wait for acceptance, then record the expected mean
   task automatic send_word(input logic [1:0] cmd, input logic [COL_BITS-1:0] col,
                            input logic [CHAN_BITS-1:0] a, b, c,
                            input bit typed = 1'b0, input logic [MEAN_BITS-1:0] typed_mean = '0);
      int                   gap;
      logic [MEAN_BITS-1:0] mean;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {{(REQ_DATA_BITS-35){1'b0}}, c, b, a, col};
      do @(posedge clock); while (!req_tready);
      if (update_profile(cmd, col, a, b, c, mean))
         pending_means.push_back('{col, typed ? typed_mean : mean});
   endtask

   // Block is idle once every mean has come back and in-flight sums have settled
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_means.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_frame_rows(input logic [ROWS_BITS-1:0] rows);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= rows;
      @(posedge clock);
      csr_wr_en    <= 1'b0;
      rows_setting  = rows;
   endtask

   // Result side: random hold-off per word, one long hold when asked
   initial begin
      int            gap;
      mean_word_type want;
      while (reset) @(posedge clock);
      forever begin
         gap = draw_gap();
         if (holds_done < hold_requests) begin
            gap = LONG_HOLD;
            holds_done++;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_means.size() == 0) begin
            errors++;
            $display("%0t: unexpected word: expected none, got column %0d mean %0d",
                     $time, rsp_tdata[10:0], rsp_tdata[18:11]);
         end else begin
            want = pending_means.pop_front();
            if (rsp_tdata[10:0] !== want.column) begin
               errors++;
               $display("%0t: out_column mismatch: expected %0d, got %0d",
                        $time, want.column, rsp_tdata[10:0]);
            end
            if (rsp_tdata[18:11] !== want.mean) begin
               errors++;
               $display("%0t: mean mismatch on column %0d: expected %0d, got %0d",
                        $time, want.column, want.mean, rsp_tdata[18:11]);
            end
         end
      end
   end

   // Watchdog: ends the run when no word moves on either side for too long
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Main sequence
   initial begin
      stim_row_type         directed_rows [NUM_DIRECTED];
      logic [ROWS_BITS-1:0] phase_rows [NUM_PHASES];
      logic [COL_BITS-1:0]  hot_cols [HOT_COLS];
      logic [1:0]           cmd;
      logic [COL_BITS-1:0]  col;
      int                   r;

      foreach (sum_store[i]) sum_store[i] = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // rows start at 720, so divisor 2160 until the first write
      directed_rows = '{
         read_row(11'h000, 8'd0),
         read_row(11'h7FF, 8'd0),
         cmd_row(CMD_ACCUM, 11'h7FF, 8'hFF, 8'hFF, 8'hFF),
         cmd_row(CMD_ACCUM, 11'h7FF, 8'hFF, 8'hFF, 8'hFF),
         read_row(11'h7FF, 8'd0),
         cfg_row(11'd1),
         read_row(11'h7FF, 8'd255),                     // 510 clamps to 255
         cmd_row(CMD_CLEAR, 11'h7FF, 8'h00, 8'h00, 8'h00),
         read_row(11'h7FF, 8'd0),
         cmd_row(CMD_ACCUM, 11'h555, 8'hAA, 8'h55, 8'h0F),
         cmd_row(CMD_READ, 11'h555, 8'h00, 8'h00, 8'h00),
         cmd_row(CMD_ACCUM, 11'h2AA, 8'h55, 8'hAA, 8'hF0),
         cmd_row(CMD_UNUSED, 11'h2AA, 8'hFF, 8'hFF, 8'hFF),
         cmd_row(CMD_READ, 11'h2AA, 8'h00, 8'h00, 8'h00),
         cfg_row(11'd0),
         read_row(11'h555, 8'd255),                     // zero rows
         read_row(11'h000, 8'd255),                     // zero rows, empty column
         cfg_row(11'd2047),
         read_row(11'h2AA, 8'd0),
         cmd_row(CMD_ACCUM, 11'h000, 8'h00, 8'h00, 8'h00),
         cmd_row(CMD_READ, 11'h000, 8'h00, 8'h00, 8'h00),
         cfg_row(11'd1024),
         read_row(11'h555, 8'd0),
         cmd_row(CMD_CLEAR, 11'h555, 8'h00, 8'h00, 8'h00)
      };
      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) set_frame_rows(directed_rows[i].rows);
         else send_word(directed_rows[i].cmd, directed_rows[i].col, directed_rows[i].chan_a,
                        directed_rows[i].chan_b, directed_rows[i].chan_c,
                        directed_rows[i].typed, directed_rows[i].mean);
      end

      // Sum overflow: drive one column past the 20-bit limit with full pixels
      set_frame_rows(11'd2047);
      idle_off = 1'b1;
      repeat (SATURATE_WORDS) begin
         send_word(CMD_ACCUM, 11'h123, 8'hFF, 8'hFF, 8'hFF);
         if ($urandom_range(0, 99) < 2) send_word(CMD_READ, 11'h123, '0, '0, '0);
      end
      send_word(CMD_READ, 11'h123, '0, '0, '0);
      send_word(CMD_ACCUM, 11'h123, 8'hFF, 8'hFF, 8'hFF);
      send_word(CMD_READ, 11'h123, '0, '0, '0);
      idle_off = 1'b0;
      set_frame_rows(11'd1024);
      send_word(CMD_READ, 11'h123, '0, '0, '0);

      // Random phases over several row settings; hot columns build up real sums
      phase_rows = '{11'd720, 11'd1, 11'd2, 11'd0, 11'd2047, 11'd1024,
                     ROWS_BITS'($urandom_range(1, 16)), ROWS_BITS'($urandom_range(3, 40))};
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_frame_rows(phase_rows[p]);
         idle_off = (p == 1 || p == 5);
         // sender keeps offering while the result side holds off
         if (p == 1) hold_requests++;
         for (int k = 0; k < HOT_COLS; k++)
            hot_cols[k] = (k == 0) ? 11'h000 : (k == 1) ? 11'h7FF :
                          COL_BITS'($urandom_range(0, 2047));
         repeat (PHASE_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 60) cmd = CMD_ACCUM;
            else if (r < 85) cmd = CMD_READ;
            else if (r < 93) cmd = CMD_CLEAR;
            else cmd = CMD_UNUSED;
            if ($urandom_range(0, 99) < 80) col = hot_cols[$urandom_range(0, HOT_COLS - 1)];
            else col = COL_BITS'($urandom_range(0, 2047));
            send_word(cmd, col, draw_channel(), draw_channel(), draw_channel());
         end
      end
      idle_off = 1'b0;

      wait_idle();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
